/* rtl/rk4_sixth_order_plant_step_core_defines.svh */
// Assertion macros shared by the plant step core.
`ifndef RK4_SIXTH_ORDER_PLANT_STEP_CORE_DEFINES_SVH
`define RK4_SIXTH_ORDER_PLANT_STEP_CORE_DEFINES_SVH

// Same-cycle implication, checked on aclk and held off during reset.
`define RK4S_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk and held off during reset.
`define RK4S_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rk4s_pkg.sv */
package rk4s_pkg;

    // Fixed-point format and vector sizes.
    localparam int FRAC_BITS = 16;
    localparam int NSTATE    = 6;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int KSUM_W    = 36;
    localparam int MAG_W     = 36;
    localparam int IDX_W     = $clog2(NSTATE);

    // The step length is Q0.32 and is always split at bit 16.
    localparam int H_SPLIT = 16;
    localparam int LO_W    = (FRAC_BITS > H_SPLIT) ? FRAC_BITS : H_SPLIT;
    localparam int HI_W    = DATA_W - ((FRAC_BITS < H_SPLIT) ? FRAC_BITS : H_SPLIT);
    localparam int MB_W    = (LO_W > HI_W) ? LO_W : HI_W;
    localparam int PROD_W  = MAG_W + MB_W;
    localparam int RES_W   = PROD_W + 1;

    // Divide-by-six unit: digits handled per cycle and number of cycles.
    localparam int DIV_W      = 40;
    localparam int DIV_DIGITS = 8;
    localparam int DIV_STEPS  = DIV_W / DIV_DIGITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Stream and configuration widths.
    localparam int TDATA_W    = NSTATE * DATA_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef word_t vec_t [NSTATE];
    typedef logic signed [KSUM_W-1:0] ksum_t;
    typedef ksum_t ksum_arr_t [NSTATE];

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEN_0,
        CFG_DEN_1,
        CFG_DEN_2,
        CFG_NUM_0,
        CFG_NUM_1,
        CFG_NUM_2,
        CFG_TIME_STEP
    } cfg_idx_t;

    // Multiplier rounding mode.
    typedef enum logic {
        MODE_QMUL,
        MODE_HSCALE
    } mul_mode_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_HI,
        MUL_SUM
    } mul_state_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_F_ISSUE,
        CS_F_WAIT,
        CS_D_ISSUE,
        CS_D_WAIT,
        CS_K,
        CS_U_ISSUE,
        CS_U_WAIT,
        CS_U_DIV,
        CS_DONE
    } ctrl_state_t;

    // Runge-Kutta stage numbers.
    localparam logic [1:0] STG_1 = 2'd0;
    localparam logic [1:0] STG_2 = 2'd1;
    localparam logic [1:0] STG_3 = 2'd2;
    localparam logic [1:0] STG_4 = 2'd3;

    typedef struct packed {
        logic idle;
        logic done;
    } ctrl_stat_t;

    localparam logic signed [ACC_W-1:0] WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] WORD_MIN = -64'sh0000_0000_8000_0000;

    // Clamp a wide signed value to the 32-bit range.
    function automatic word_t sat32(input logic signed [ACC_W-1:0] v);
        word_t r;
        if (v > WORD_MAX) begin
            r = WORD_MAX[DATA_W-1:0];
        end else if (v < WORD_MIN) begin
            r = WORD_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input word_t v);
        logic [DATA_W-1:0] b;
        b = v;
        return v[DATA_W-1] ? (~b + 32'd1) : b;
    endfunction

    function automatic logic [MAG_W-1:0] mag36(input ksum_t v);
        logic [MAG_W-1:0] b;
        b = v;
        return v[KSUM_W-1] ? (~b + 36'd1) : b;
    endfunction

endpackage

/* rtl/rk4_sixth_order_plant_step_core.sv */
// Each input transfer runs 54 products on the shared multiplier, four slope captures
// and six divide passes before the result is valid.
// A new item is taken only once the sequencer has returned to idle.
// A new item is taken while the previous result still waits in the output register.
// Reset (aresetn low at a clock edge) clears the plant state, all configuration
// registers and the output valid, and returns the sequencer to idle.
`include "rk4_sixth_order_plant_step_core_defines.svh"

module rk4_sixth_order_plant_step_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // drive_value, drive_deriv_1 .. drive_deriv_5, 32 bits each, lowest first
    input  logic [rk4s_pkg::TDATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // plant_out, out_deriv_1 .. out_deriv_5, 32 bits each, lowest first
    output logic [rk4s_pkg::TDATA_W-1:0]    m_tdata,
    input  logic                            cfg_we,
    input  logic [rk4s_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rk4s_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rk4s_pkg::*;

    logic [CFG_DATA_W-1:0] den0_reg, den1_reg, den2_reg;
    logic [CFG_DATA_W-1:0] num0_reg, num1_reg, num2_reg;
    logic [31:0]           h_reg;
    logic                  m_tvalid_reg;
    logic [TDATA_W-1:0]    m_tdata_reg;

    vec_t       dc, nc, u, x;
    ctrl_stat_t stat;
    logic       take;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            den0_reg <= '0;
            den1_reg <= '0;
            den2_reg <= '0;
            num0_reg <= '0;
            num1_reg <= '0;
            num2_reg <= '0;
            h_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEN_0:     den0_reg <= cfg_data;
                CFG_DEN_1:     den1_reg <= cfg_data;
                CFG_DEN_2:     den2_reg <= cfg_data;
                CFG_NUM_0:     num0_reg <= cfg_data;
                CFG_NUM_1:     num1_reg <= cfg_data;
                CFG_NUM_2:     num2_reg <= cfg_data;
                CFG_TIME_STEP: h_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Coefficient unpacking: pair 0 holds the highest-order terms.
    assign dc[5] = den0_reg[31:0];
    assign dc[4] = den0_reg[63:32];
    assign dc[3] = den1_reg[31:0];
    assign dc[2] = den1_reg[63:32];
    assign dc[1] = den2_reg[31:0];
    assign dc[0] = den2_reg[63:32];
    assign nc[5] = num0_reg[31:0];
    assign nc[4] = num0_reg[63:32];
    assign nc[3] = num1_reg[31:0];
    assign nc[2] = num1_reg[63:32];
    assign nc[1] = num2_reg[31:0];
    assign nc[0] = num2_reg[63:32];

    always_comb begin
        for (int i = 0; i < NSTATE; i++) begin
            u[i] = s_tdata[i*DATA_W +: DATA_W];
        end
    end

    rk4s_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (s_tvalid && s_tready),
        .u_i     (u),
        .dc_i    (dc),
        .nc_i    (nc),
        .h_i     (h_reg),
        .take_i  (take),
        .stat_o  (stat),
        .x_o     (x)
    );

    assign s_tready = stat.idle;

    // Output register: loaded when a result is ready and the slot is free.
    assign take = stat.done && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < NSTATE; i++) begin
                m_tdata_reg[i*DATA_W +: DATA_W] <= x[i];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on sequencing and the output register.
    `RK4S_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after input transfer")
    `RK4S_ASSERT_IMP(a_idle_done_excl, 1'b1, $onehot0({stat.idle, stat.done}), "idle and done together")
    `RK4S_ASSERT_IMP(a_load_from_done, $rose(m_tvalid), $past(stat.done), "result without finished step")
    `RK4S_ASSERT_NXT(a_drain, m_tvalid && m_tready && !stat.done, !m_tvalid, "result repeated")

endmodule

/* rtl/rk4s_mul.sv */
module rk4s_mul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start_i,
    input  rk4s_pkg::mul_mode_t       mode_i,
    input  logic [rk4s_pkg::MAG_W-1:0] a_i,
    input  logic [31:0]               b_i,
    output logic                      done_o,
    output logic [rk4s_pkg::RES_W-1:0] res_o
);
    import rk4s_pkg::*;

    localparam logic [31:0] HS_LO_MASK = 32'((64'd1 << H_SPLIT) - 64'd1);
    localparam logic [31:0] FR_LO_MASK = 32'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [PROD_W-1:0] QMUL_RND = PROD_W'(1) << (FRAC_BITS - 1);

    mul_state_t        state_reg, state_next;
    logic [MAG_W-1:0]  a_reg;
    logic [31:0]       b_reg;
    mul_mode_t         mode_reg;
    logic [PROD_W-1:0] prod_reg, pre_reg;
    logic [RES_W-1:0]  res_reg;
    logic              done_reg;

    logic [31:0]       lo_full, hi_full;
    logic [MAG_W-1:0]  mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [PROD_W-1:0] prod, pre;

    // Low half of the second operand on start, high half on the next cycle.
    assign lo_full = (mode_i == MODE_HSCALE) ? (b_i & HS_LO_MASK) : (b_i & FR_LO_MASK);
    assign hi_full = (mode_reg == MODE_HSCALE) ? (b_reg >> H_SPLIT) : (b_reg >> FRAC_BITS);
    assign mul_a   = (state_reg == MUL_IDLE) ? a_i : a_reg;
    assign mul_b   = (state_reg == MUL_IDLE) ? lo_full[MB_W-1:0] : hi_full[MB_W-1:0];
    assign prod    = {{MB_W{1'b0}}, mul_a} * {{MAG_W{1'b0}}, mul_b};

    // Low partial product scaled down, rounded only for coefficient products.
    assign pre = (mode_reg == MODE_HSCALE) ? (prod_reg >> H_SPLIT)
                                           : ((prod_reg + QMUL_RND) >> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MUL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MUL_SUM);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MUL_IDLE: if (start_i) state_next = MUL_HI;
            MUL_HI:   state_next = MUL_SUM;
            MUL_SUM:  state_next = MUL_IDLE;
            default:  state_next = MUL_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            MUL_IDLE: begin
                if (start_i) begin
                    a_reg    <= a_i;
                    b_reg    <= b_i;
                    mode_reg <= mode_i;
                    prod_reg <= prod;
                end
            end
            MUL_HI: begin
                pre_reg  <= pre;
                prod_reg <= prod;
            end
            MUL_SUM: begin
                res_reg <= {1'b0, prod_reg} + {1'b0, pre_reg};
            end
            default: ;
        endcase
    end

    assign done_o = done_reg;
    assign res_o  = res_reg;

endmodule

/* rtl/rk4s_div6.sv */
module rk4s_div6 (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start_i,
    input  logic [rk4s_pkg::DIV_W-1:0] val_i,
    output logic                       done_o,
    output logic [rk4s_pkg::DIV_W-1:0] quo_o
);
    import rk4s_pkg::*;

    localparam logic [3:0] DIVISOR = 4'd6;

    logic                 busy_reg, done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     val_reg, quo_reg;
    logic [2:0]           rem_reg;

    logic [2:0]            rem_next;
    logic [DIV_DIGITS-1:0] digs;
    logic [3:0]            trial;

    // Restoring long division, a fixed number of quotient bits per cycle.
    always_comb begin
        rem_next = rem_reg;
        trial    = 4'd0;
        digs     = '0;
        for (int j = DIV_DIGITS - 1; j >= 0; j--) begin
            trial = {rem_next, val_reg[DIV_W - DIV_DIGITS + j]};
            if (trial >= DIVISOR) begin
                trial   = trial - DIVISOR;
                digs[j] = 1'b1;
            end
            rem_next = trial[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            val_reg <= val_i;
            rem_reg <= 3'd0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            val_reg <= val_reg << DIV_DIGITS;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-DIV_DIGITS-1:0], digs};
        end
    end

    assign done_o = done_reg;
    assign quo_o  = quo_reg;

endmodule

/* rtl/rk4s_ctrl.sv */
module rk4s_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start_i,
    input  rk4s_pkg::vec_t       u_i,
    input  rk4s_pkg::vec_t       dc_i,
    input  rk4s_pkg::vec_t       nc_i,
    input  logic [31:0]          h_i,
    input  logic                 take_i,
    output rk4s_pkg::ctrl_stat_t stat_o,
    output rk4s_pkg::vec_t       x_o
);
    import rk4s_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NSTATE - 1);
    localparam logic [ACC_W-1:0] HS_RND1  = 64'd1 << (H_SPLIT - 1);
    localparam logic [ACC_W-1:0] HS_RND2  = 64'd1 << H_SPLIT;
    localparam logic [ACC_W-1:0] HS_RND6  = 64'd3 << H_SPLIT;

    ctrl_state_t             state_reg, state_next;
    logic [1:0]              stage_reg, stage_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    vec_t                    x_reg, x_next;
    vec_t                    xs_reg, xs_next;
    vec_t                    u_reg, u_next;
    vec_t                    k_reg, k_next;
    ksum_arr_t               ksum_reg, ksum_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] force_reg, force_next;
    logic                    neg_reg, neg_next;

    logic                    mul_start, mul_done;
    mul_mode_t               mul_mode;
    logic [MAG_W-1:0]        mul_a;
    logic [31:0]             mul_b;
    logic [RES_W-1:0]        mul_res;
    logic                    issue_neg;
    logic                    div_start, div_done;
    logic [DIV_W-1:0]        div_quo;

    ksum_t                   upd_v;
    logic signed [ACC_W-1:0] term, upd_s;
    logic [ACC_W-1:0]        q64, hs_r, upd_r, div_in64;
    word_t                   upd_new;
    vec_t                    k_new;
    ksum_arr_t               ksum_upd;

    rk4s_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (mul_start),
        .mode_i  (mul_mode),
        .a_i     (mul_a),
        .b_i     (mul_b),
        .done_o  (mul_done),
        .res_o   (mul_res)
    );

    rk4s_div6 u_div6 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .val_i   (div_in64[DIV_W-1:0]),
        .done_o  (div_done),
        .quo_o   (div_quo)
    );

    // Operand selection for the shared multiplier, sign-magnitude form.
    assign upd_v = (stage_reg == STG_4) ? ksum_reg[idx_reg] : KSUM_W'(k_reg[idx_reg]);

    always_comb begin
        case (state_reg)
            CS_D_ISSUE: begin
                mul_a     = MAG_W'(mag32(dc_i[idx_reg]));
                mul_b     = mag32(xs_reg[idx_reg]);
                mul_mode  = MODE_QMUL;
                issue_neg = dc_i[idx_reg][DATA_W-1] ^ xs_reg[idx_reg][DATA_W-1];
            end
            CS_U_ISSUE: begin
                mul_a     = mag36(upd_v);
                mul_b     = h_i;
                mul_mode  = MODE_HSCALE;
                issue_neg = upd_v[KSUM_W-1];
            end
            default: begin
                mul_a     = MAG_W'(mag32(nc_i[idx_reg]));
                mul_b     = mag32(u_reg[idx_reg]);
                mul_mode  = MODE_QMUL;
                issue_neg = nc_i[idx_reg][DATA_W-1] ^ u_reg[idx_reg][DATA_W-1];
            end
        endcase
    end

    // Signed product term for the forcing and weighted state sums.
    assign q64  = 64'(mul_res);
    assign term = neg_reg ? -$signed(q64) : $signed(q64);

    // Step scaling: half step, full step, or the final sixth with the divider.
    assign hs_r     = (stage_reg == STG_3) ? ((q64 + HS_RND1) >> H_SPLIT)
                                           : ((q64 + HS_RND2) >> (H_SPLIT + 1));
    assign div_in64 = (q64 + HS_RND6) >> H_SPLIT;
    assign upd_r    = (stage_reg == STG_4) ? 64'(div_quo) : hs_r;
    assign upd_s    = neg_reg ? -$signed(upd_r) : $signed(upd_r);
    assign upd_new  = sat32(64'(x_reg[idx_reg]) + upd_s);

    // Stage slope and its weighted running sum.
    always_comb begin
        for (int i = 0; i < NSTATE - 1; i++) begin
            k_new[i] = xs_reg[i+1];
        end
        k_new[NSTATE-1] = sat32(acc_reg);
        for (int i = 0; i < NSTATE; i++) begin
            if (stage_reg == STG_1) begin
                ksum_upd[i] = KSUM_W'(k_new[i]);
            end else if (stage_reg == STG_4) begin
                ksum_upd[i] = ksum_reg[i] + KSUM_W'(k_new[i]);
            end else begin
                ksum_upd[i] = ksum_reg[i] + (KSUM_W'(k_new[i]) <<< 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            stage_reg <= STG_1;
            idx_reg   <= '0;
            for (int i = 0; i < NSTATE; i++) begin
                x_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            idx_reg   <= idx_next;
            x_reg     <= x_next;
        end
    end

    always_ff @(posedge aclk) begin
        xs_reg    <= xs_next;
        u_reg     <= u_next;
        k_reg     <= k_next;
        ksum_reg  <= ksum_next;
        acc_reg   <= acc_next;
        force_reg <= force_next;
        neg_reg   <= neg_next;
    end

    // Sequencer: forcing sum, then four slope evaluations with state updates.
    always_comb begin
        state_next = state_reg;
        stage_next = stage_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        xs_next    = xs_reg;
        u_next     = u_reg;
        k_next     = k_reg;
        ksum_next  = ksum_reg;
        acc_next   = acc_reg;
        force_next = force_reg;
        neg_next   = neg_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                if (start_i) begin
                    u_next     = u_i;
                    xs_next    = x_reg;
                    acc_next   = '0;
                    stage_next = STG_1;
                    idx_next   = '0;
                    state_next = CS_F_ISSUE;
                end
            end
            CS_F_ISSUE, CS_D_ISSUE, CS_U_ISSUE: begin
                mul_start = 1'b1;
                neg_next  = issue_neg;
                case (state_reg)
                    CS_F_ISSUE: state_next = CS_F_WAIT;
                    CS_D_ISSUE: state_next = CS_D_WAIT;
                    default:    state_next = CS_U_WAIT;
                endcase
            end
            CS_F_WAIT: begin
                if (mul_done) begin
                    acc_next = acc_reg + term;
                    if (idx_reg == LAST_IDX) begin
                        force_next = acc_reg + term;
                        idx_next   = '0;
                        state_next = CS_D_ISSUE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = CS_F_ISSUE;
                    end
                end
            end
            CS_D_WAIT: begin
                if (mul_done) begin
                    acc_next = acc_reg - term;
                    if (idx_reg == LAST_IDX) begin
                        state_next = CS_K;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = CS_D_ISSUE;
                    end
                end
            end
            CS_K: begin
                k_next     = k_new;
                ksum_next  = ksum_upd;
                idx_next   = '0;
                state_next = CS_U_ISSUE;
            end
            CS_U_WAIT, CS_U_DIV: begin
                if (state_reg == CS_U_WAIT && mul_done && stage_reg == STG_4) begin
                    div_start  = 1'b1;
                    state_next = CS_U_DIV;
                end else if ((state_reg == CS_U_WAIT && mul_done) ||
                             (state_reg == CS_U_DIV && div_done)) begin
                    if (stage_reg == STG_4) begin
                        x_next[idx_reg] = upd_new;
                    end else begin
                        xs_next[idx_reg] = upd_new;
                    end
                    if (idx_reg != LAST_IDX) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = CS_U_ISSUE;
                    end else if (stage_reg == STG_4) begin
                        state_next = CS_DONE;
                    end else begin
                        stage_next = stage_reg + 1'b1;
                        idx_next   = '0;
                        acc_next   = force_reg;
                        state_next = CS_D_ISSUE;
                    end
                end
            end
            CS_DONE: begin
                if (take_i) state_next = CS_IDLE;
            end
            default: state_next = CS_IDLE;
        endcase
    end

    assign stat_o.idle = (state_reg == CS_IDLE);
    assign stat_o.done = (state_reg == CS_DONE);
    assign x_o         = x_reg;

endmodule
